// ===== sv/sale_pkg.sv =====
// Shared types and constants for the shift array list engine.
// Depends on nothing; sale_cell, sale_ctrl and the top level use it through scoped names.
package sale_pkg;

    localparam int DEPTH    = 128;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = IDX_W + 1;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 16;
    localparam int KIND_W   = 3;
    localparam int STAT_W   = 3;
    localparam int FOUND_W  = 7;
    localparam int COUNT_W  = 8;

    localparam logic [KIND_W-1:0] K_PUSH    = 3'd0;
    localparam logic [KIND_W-1:0] K_INSERT  = 3'd1;
    localparam logic [KIND_W-1:0] K_DEL_POS = 3'd2;
    localparam logic [KIND_W-1:0] K_DEL_VAL = 3'd3;
    localparam logic [KIND_W-1:0] K_READ    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_CLAMPED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_INVALID  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    typedef logic [DEPTH-1:0][WORD_W-1:0] t_word_row;

    typedef struct packed {
        logic              we;
        logic              ins;
        logic              del;
        logic              use_mask;
        logic [IDX_W-1:0]  at;
        logic [WORD_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } t_cell_ctl;

    typedef struct packed {
        logic              ins;
        logic              del_pos;
        logic              del_val;
        logic [IDX_W-1:0]  at;
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] rd;
    } t_plan;

endpackage

// ===== sv/sale_if.sv =====
// Command and response channel interfaces (valid/ready with payload).
// Depends on nothing.
interface sale_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic signed [15:0] position;

    modport source (output valid, output kind, output value, output position, input ready);
    modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface sale_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         found_position;
    logic [7:0]         count;

    modport source (output valid, output status, output read_value,
                    output found_position, output count, input ready);
    modport sink   (input valid, input status, input read_value,
                    input found_position, input count, output ready);
endinterface

// ===== sv/sale_cell.sv =====
// One storage cell of the list: holds a word, shifts from its neighbors, flags a match.
// Depends on sale_pkg.
module sale_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sale_pkg::t_cell_ctl           i_ctl,
    input  logic [sale_pkg::IDX_W-1:0]    i_idx,
    input  logic [sale_pkg::WORD_W-1:0]   i_left,
    input  logic [sale_pkg::WORD_W-1:0]   i_right,
    input  logic                          i_ge,
    output logic [sale_pkg::WORD_W-1:0]   o_word,
    output logic                          o_match
);

    logic [sale_pkg::WORD_W-1:0] r_word;
    logic [sale_pkg::WORD_W-1:0] n_word;
    logic                        r_match;
    logic                        ge_sel;

    always_comb begin
        ge_sel = i_ctl.use_mask ? i_ge : (i_idx >= i_ctl.at);
        n_word = r_word;
        if (i_ctl.we) begin
            if (i_ctl.ins) begin
                if (i_idx > i_ctl.at) begin
                    n_word = i_left;
                end else if (i_idx == i_ctl.at) begin
                    n_word = i_ctl.value;
                end
            end else if (i_ctl.del && ge_sel) begin
                n_word = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_match <= 1'b0;
        end else begin
            r_word  <= n_word;
            r_match <= (r_word == i_ctl.value) && ({1'b0, i_idx} < i_ctl.count);
        end
    end

    assign o_word  = r_word;
    assign o_match = r_match;

endmodule

// ===== sv/sale_ctrl.sv =====
// Command sequencer: latches a transfer, plans the update, drives the cell row,
// finds the first match and holds the response register. Depends on sale_pkg, sale_if.
module sale_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sale_cmd_if.sink                      i_cmd,
    sale_rsp_if.source                    o_rsp,
    input  sale_pkg::t_word_row           i_words,
    input  logic [sale_pkg::DEPTH-1:0]    i_match,
    output sale_pkg::t_cell_ctl           o_ctl,
    output logic [sale_pkg::DEPTH-1:0]    o_ge
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [sale_pkg::KIND_W-1:0]    r_kind;
    logic [sale_pkg::WORD_W-1:0]    r_value;
    logic [sale_pkg::POS_W-1:0]     r_pos;
    logic [sale_pkg::CNT_W-1:0]     r_count;
    logic [sale_pkg::CNT_W-1:0]     n_count;
    sale_pkg::t_plan                r_plan;
    sale_pkg::t_plan                n_plan;

    logic                           r_out_valid;
    logic [sale_pkg::STAT_W-1:0]    r_out_status;
    logic [sale_pkg::WORD_W-1:0]    r_out_rd;
    logic [sale_pkg::FOUND_W-1:0]   r_out_found;
    logic [sale_pkg::COUNT_W-1:0]   r_out_count;

    logic                           out_free;
    logic                           upd_go;
    logic [sale_pkg::POS_W-1:0]     cnt_ext;
    logic                           pos_neg;
    logic                           pos_lt_cnt;
    logic                           pos_gt_cnt;
    logic                           full;
    logic [sale_pkg::DEPTH-1:0]     low_bits;
    logic [sale_pkg::DEPTH-1:0]     first_hot;
    logic                           hit;
    logic                           del;
    logic [sale_pkg::IDX_W-1:0]     found_idx;
    logic [sale_pkg::IDX_W+sale_pkg::FOUND_W-1:0] found_wide;
    logic [sale_pkg::CNT_W+sale_pkg::COUNT_W-1:0] count_wide;
    logic [sale_pkg::STAT_W-1:0]    fin_status;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign upd_go   = (r_state == S_UPD) && out_free;

    assign i_cmd.ready = (r_state == S_IDLE) && i_rst_n;

    // plan the command against the current count
    always_comb begin
        cnt_ext    = {{(sale_pkg::POS_W-sale_pkg::CNT_W){1'b0}}, r_count};
        pos_neg    = r_pos[sale_pkg::POS_W-1];
        pos_lt_cnt = !pos_neg && (r_pos < cnt_ext);
        pos_gt_cnt = !pos_neg && (r_pos > cnt_ext);
        full       = r_count >= sale_pkg::CNT_W'(sale_pkg::DEPTH);
        n_plan     = '0;
        n_plan.status = sale_pkg::ST_OK;
        case (r_kind)
            sale_pkg::K_PUSH: begin
                if (full) begin
                    n_plan.status = sale_pkg::ST_FULL;
                end else begin
                    n_plan.ins = 1'b1;
                end
            end
            sale_pkg::K_INSERT: begin
                if (full) begin
                    n_plan.status = sale_pkg::ST_FULL;
                end else begin
                    n_plan.ins = 1'b1;
                    if (pos_neg) begin
                        n_plan.status = sale_pkg::ST_CLAMPED;
                    end else if (pos_gt_cnt) begin
                        n_plan.at     = r_count[sale_pkg::IDX_W-1:0];
                        n_plan.status = sale_pkg::ST_CLAMPED;
                    end else begin
                        n_plan.at = r_pos[sale_pkg::IDX_W-1:0];
                    end
                end
            end
            sale_pkg::K_DEL_POS: begin
                if (pos_lt_cnt) begin
                    n_plan.del_pos = 1'b1;
                    n_plan.at      = r_pos[sale_pkg::IDX_W-1:0];
                end else begin
                    n_plan.status = sale_pkg::ST_INVALID;
                end
            end
            sale_pkg::K_DEL_VAL: begin
                n_plan.del_val = 1'b1;
            end
            sale_pkg::K_READ: begin
                if (pos_lt_cnt) begin
                    n_plan.rd = i_words[r_pos[sale_pkg::IDX_W-1:0]];
                end else begin
                    n_plan.status = sale_pkg::ST_INVALID;
                end
            end
            default: begin
                n_plan.status = sale_pkg::ST_OK;
            end
        endcase
    end

    // isolate the first match and the cells at or above it
    always_comb begin
        low_bits  = i_match ^ (i_match - 1'b1);
        first_hot = i_match & low_bits;
        hit       = |i_match;
        o_ge      = ~(low_bits >> 1);
        found_idx = '0;
        for (int i = 0; i < sale_pkg::DEPTH; i++) begin
            if (first_hot[i]) begin
                found_idx = found_idx | sale_pkg::IDX_W'(i);
            end
        end
        found_wide = {{sale_pkg::FOUND_W{1'b0}}, found_idx};
        del        = r_plan.del_pos || (r_plan.del_val && hit);
        if (r_plan.ins) begin
            n_count = r_count + 1'b1;
        end else if (del) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
        count_wide = {{sale_pkg::COUNT_W{1'b0}}, n_count};
        if (r_plan.del_val) begin
            fin_status = hit ? sale_pkg::ST_OK : sale_pkg::ST_NOTFOUND;
        end else begin
            fin_status = r_plan.status;
        end
    end

    always_comb begin
        o_ctl.we       = upd_go;
        o_ctl.ins      = r_plan.ins;
        o_ctl.del      = del;
        o_ctl.use_mask = r_plan.del_val;
        o_ctl.at       = r_plan.at;
        o_ctl.value    = r_value;
        o_ctl.count    = r_count;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (upd_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_kind  <= i_cmd.kind;
            r_value <= i_cmd.value;
            r_pos   <= i_cmd.position;
        end
        if (r_state == S_CMP) begin
            r_plan <= n_plan;
        end
        if (upd_go) begin
            r_out_status <= fin_status;
            r_out_rd     <= r_plan.rd;
            r_out_found  <= (r_plan.del_val && hit) ? found_wide[sale_pkg::FOUND_W-1:0] : '0;
            r_out_count  <= count_wide[sale_pkg::COUNT_W-1:0];
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.read_value     = r_out_rd;
    assign o_rsp.found_position = r_out_found;
    assign o_rsp.count          = r_out_count;

endmodule

// ===== sv/shift_array_list_engine_unit.sv =====
// Top level: ordered list of signed words kept in a row of shifting cells.
// Depends on sale_pkg, sale_if, sale_cell, sale_ctrl.
//
//   port    dir   payload                                      transfer when
//   i_cmd   in    kind, value, position                        valid && ready
//   o_rsp   out   status, read_value, found_position, count    valid && ready
//
// A command is handled in order: the transfer is latched; then every cell
// compares its word and the command is planned; then the whole row is
// updated at once and the response register is loaded.
// The next command is taken while the previous response waits; the update
// step holds while the response register is still full.
// Synchronous active-low reset clears every cell, the count and both handshakes.
module shift_array_list_engine_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sale_cmd_if.sink   i_cmd,
    sale_rsp_if.source o_rsp
);

    sale_pkg::t_word_row             w_words;
    sale_pkg::t_word_row             w_left;
    sale_pkg::t_word_row             w_right;
    logic [sale_pkg::DEPTH-1:0]      w_match;
    logic [sale_pkg::DEPTH-1:0]      w_ge;
    sale_pkg::t_cell_ctl             w_ctl;

    assign w_left  = {w_words[sale_pkg::DEPTH-2:0], {sale_pkg::WORD_W{1'b0}}};
    assign w_right = {{sale_pkg::WORD_W{1'b0}}, w_words[sale_pkg::DEPTH-1:1]};

    sale_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_rsp   (o_rsp),
        .i_words (w_words),
        .i_match (w_match),
        .o_ctl   (w_ctl),
        .o_ge    (w_ge)
    );

    for (genvar g = 0; g < sale_pkg::DEPTH; g++) begin : g_cell
        sale_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_idx   (sale_pkg::IDX_W'(g)),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_ge    (w_ge[g]),
            .o_word  (w_words[g]),
            .o_match (w_match[g])
        );
    end

endmodule
